### src/dlwb_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and sizes for the dirty-line write-back byte store.
package dlwb_pkg;

  // Store geometry
  localparam int STORE_BYTES   = 4096;
  localparam int ADDR_W        = $clog2(STORE_BYTES);
  localparam int LINE_SHIFT    = 7;
  localparam int LINE_IDX_W    = ADDR_W - LINE_SHIFT;
  localparam int LINE_COUNT    = 1 << LINE_IDX_W;
  localparam int MAX_RUN_BYTES = 1024;
  localparam int MAX_RUN_LINES = MAX_RUN_BYTES >> LINE_SHIFT;
  localparam int RUN_CNT_W     = $clog2(MAX_RUN_LINES + 1);

  // Command kinds
  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_FLUSH = 2'd2;

  // Access size codes
  localparam logic [1:0] SIZE_1 = 2'd0;
  localparam logic [1:0] SIZE_2 = 2'd1;
  localparam logic [1:0] SIZE_4 = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] address;
    logic [1:0]  access_size;
    logic [31:0] write_value;
    logic        sink_ok;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic        in_range;
    logic        flush_valid;
    logic [4:0]  flush_first_line;
    logic [3:0]  flush_line_count;
    logic        sync_request;
  } out_item_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_REQ,
    ST_RD_CAP,
    ST_WR,
    ST_SCAN,
    ST_DONE
  } seq_state_t;

  // Dirty map operations
  typedef enum logic [1:0] {
    DM_NONE,
    DM_ACTIVATE,
    DM_MARK,
    DM_SCAN
  } dm_op_t;

  // Run scanner phases
  typedef enum logic [1:0] {
    SCAN_IDLE,
    SCAN_FIND,
    SCAN_EXTEND
  } scan_phase_t;

  typedef struct packed {
    dm_op_t                op;
    logic [LINE_IDX_W-1:0] first_line;
    logic [LINE_IDX_W-1:0] last_line;
    logic                  sink_ok;
  } dm_cmd_t;

  typedef struct packed {
    logic                  active;
    logic                  any_dirty;
    logic                  scan_done;
    logic                  run_found;
    logic [LINE_IDX_W-1:0] run_first;
    logic [RUN_CNT_W-1:0]  run_count;
    logic                  sync;
  } dm_stat_t;

endpackage

### src/dirty_line_write_back_store_unit.sv
`timescale 1ns / 1ps
// Top level: command sequencer, byte assembly and result register.
//
// Write-back byte store of 4096 bytes in 32 lines of 128 bytes with a dirty-line
// mask. After reset the block sweeps the byte RAM to zero, one byte a cycle, and
// holds busy high for the whole sweep. A command is taken when start is high and
// busy is low; exactly one result follows, shown on result for the single cycle
// in which done is high, and it must be taken then. Every byte goes through the
// one RAM port: a read or a write fetches and compares each byte in turn (read
// request, then capture), a write that changes data then stores each byte, and
// the result is shown in the done state before the return to idle. A flush tick
// steps the scanner one line a cycle until the run ends, then shows the result. A
// command that touches no byte and issues no run goes straight to the done state.
module dirty_line_write_back_store_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  dlwb_pkg::in_item_t  item,
  output logic                done,
  output dlwb_pkg::out_item_t result
);
  import dlwb_pkg::*;

  seq_state_t          state;
  seq_state_t          state_next;
  in_item_t            cmd;
  out_item_t           res;
  logic [ADDR_W-1:0]   clr_cnt;
  logic [1:0]          k;
  logic [1:0]          len_m1;
  logic                differs;
  logic [31:0]         acc;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_addr;
  logic [7:0]          ram_wdata;
  logic [7:0]          ram_rdata;
  dm_cmd_t             dm_cmd;
  dm_stat_t            dm_stat;

  logic                accept;
  logic                item_rw;
  logic                size_ok;
  logic [1:0]          item_len_m1;
  logic [16:0]         item_end;
  logic                range_ok;
  logic                flush_ok;
  logic [ADDR_W-1:0]   byte_addr;
  logic [ADDR_W-1:0]   last_addr;
  logic [7:0]          wr_byte;
  logic                last_byte;
  logic                differs_now;
  logic [31:0]         acc_next;

  dlwb_byte_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  dlwb_dirty_map u_map (
    .clk  (clk),
    .rst  (rst),
    .cmd  (dm_cmd),
    .stat (dm_stat)
  );

  // Decode the offered command
  assign accept  = start && (state == ST_IDLE);
  assign item_rw = (item.kind inside {KIND_READ, KIND_WRITE});
  assign size_ok = (item.access_size inside {SIZE_1, SIZE_2, SIZE_4});
  always_comb begin
    case (item.access_size)
      SIZE_2:  item_len_m1 = 2'd1;
      SIZE_4:  item_len_m1 = 2'd3;
      default: item_len_m1 = 2'd0;
    endcase
  end
  assign item_end = {1'b0, item.address} + 17'(item_len_m1);
  assign range_ok = size_ok && (item_end < 17'(STORE_BYTES));
  assign flush_ok = dm_stat.active && dm_stat.any_dirty;

  // Per-byte datapath: one byte compared and merged a step
  assign byte_addr   = cmd.address[ADDR_W-1:0] + ADDR_W'(k);
  assign last_addr   = cmd.address[ADDR_W-1:0] + ADDR_W'(len_m1);
  assign wr_byte     = cmd.write_value[{k, 3'b000} +: 8];
  assign last_byte   = (k == len_m1);
  assign differs_now = differs || (ram_rdata != wr_byte);
  assign acc_next    = acc | (32'(ram_rdata) << {k, 3'b000});

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_cnt == {ADDR_W{1'b1}}) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          case (item.kind)
            KIND_READ, KIND_WRITE: state_next = range_ok ? ST_RD_REQ : ST_DONE;
            KIND_FLUSH:            state_next = flush_ok ? ST_SCAN : ST_DONE;
            default:               state_next = ST_DONE;
          endcase
        end
      end
      ST_RD_REQ: state_next = ST_RD_CAP;
      ST_RD_CAP: begin
        if (!last_byte) begin
          state_next = ST_RD_REQ;
        end else if (cmd.kind == KIND_WRITE && differs_now) begin
          state_next = ST_WR;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_WR: begin
        if (last_byte) begin
          state_next = ST_DONE;
        end
      end
      ST_SCAN: begin
        if (dm_stat.scan_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs: RAM port and dirty map commands
  always_comb begin
    ram_we            = 1'b0;
    ram_addr          = byte_addr;
    ram_wdata         = wr_byte;
    dm_cmd.op         = DM_NONE;
    dm_cmd.first_line = cmd.address[ADDR_W-1:LINE_SHIFT];
    dm_cmd.last_line  = last_addr[ADDR_W-1:LINE_SHIFT];
    dm_cmd.sink_ok    = item.sink_ok;
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_cnt;
        ram_wdata = '0;
      end
      ST_IDLE: begin
        if (start && item.kind == KIND_FLUSH && flush_ok) begin
          dm_cmd.op = DM_SCAN;
        end
      end
      ST_RD_CAP: begin
        if (last_byte) begin
          if (cmd.kind == KIND_READ) begin
            dm_cmd.op = DM_ACTIVATE;
          end else if (differs_now) begin
            dm_cmd.op = DM_MARK;
          end
        end
      end
      ST_WR: ram_we = 1'b1;
      default: ;
    endcase
  end

  assign busy   = (state != ST_IDLE);
  assign done   = (state == ST_DONE);
  assign result = res;

  // State register and clearing sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  // Payload: hold the command, gather bytes, build the result
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd          <= item;
          len_m1       <= item_len_m1;
          k            <= '0;
          differs      <= 1'b0;
          acc          <= '0;
          res          <= '0;
          res.in_range <= item_rw && range_ok;
        end
      end
      ST_RD_CAP: begin
        acc     <= acc_next;
        differs <= differs_now;
        k       <= last_byte ? 2'd0 : k + 1'b1;
        if (last_byte && cmd.kind == KIND_READ) begin
          res.read_value <= acc_next;
        end
      end
      ST_WR: k <= k + 1'b1;
      ST_SCAN: begin
        if (dm_stat.scan_done && dm_stat.run_found) begin
          res.flush_valid      <= 1'b1;
          res.flush_first_line <= 5'(dm_stat.run_first);
          res.flush_line_count <= 4'(dm_stat.run_count);
          res.sync_request     <= dm_stat.sync;
        end
      end
      default: ;
    endcase
  end

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  a_done_one_cycle: assert property (@(posedge clk) disable iff (rst)
    done |=> (!done && !busy))
    else $error("result strobe longer than one cycle");

  a_result_exclusive: assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.flush_valid && result.in_range))
    else $error("result reports both an access and a flush run");

  a_write_within_line_pair: assert property (@(posedge clk) disable iff (rst)
    (dm_cmd.op == DM_MARK) |->
      (dm_cmd.last_line == dm_cmd.first_line ||
       dm_cmd.last_line == dm_cmd.first_line + 1'b1))
    else $error("write spans more than two lines");

endmodule

### src/dlwb_byte_ram.sv
`timescale 1ns / 1ps
// Single-port byte RAM with registered read data.
module dlwb_byte_ram (
  input  logic                      clk,
  input  logic                      we,
  input  logic [dlwb_pkg::ADDR_W-1:0] addr,
  input  logic [7:0]                wdata,
  output logic [7:0]                rdata
);
  import dlwb_pkg::*;

  logic [7:0] mem [STORE_BYTES];

  // Write one byte, read one byte per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### src/dlwb_dirty_map.sv
`timescale 1ns / 1ps
// Dirty-line mask, activation flag and iterative flush-run scanner.
module dlwb_dirty_map (
  input  logic               clk,
  input  logic               rst,
  input  dlwb_pkg::dm_cmd_t  cmd,
  output dlwb_pkg::dm_stat_t stat
);
  import dlwb_pkg::*;

  logic [LINE_COUNT-1:0]  dirty;
  logic                   active;
  scan_phase_t            phase;
  scan_phase_t            phase_next;
  logic [LINE_IDX_W:0]    idx;
  logic [LINE_IDX_W-1:0]  run_first;
  logic [RUN_CNT_W-1:0]   run_len;
  logic                   keep;
  logic                   done_pulse;
  logic                   found;
  logic                   idx_end;
  logic                   idx_hit;
  logic                   extend_ok;

  function automatic logic [LINE_COUNT-1:0] line_mask(input logic [LINE_IDX_W-1:0] line);
    line_mask = LINE_COUNT'(1) << line;
  endfunction

  // Probe the line under the scan pointer
  assign idx_end   = (idx == (LINE_IDX_W + 1)'(LINE_COUNT));
  assign idx_hit   = !idx_end && dirty[idx[LINE_IDX_W-1:0]];
  assign extend_ok = idx_hit && (run_len < RUN_CNT_W'(MAX_RUN_LINES));

  // Scanner next phase
  always_comb begin
    phase_next = phase;
    case (phase)
      SCAN_IDLE: begin
        if (cmd.op == DM_SCAN) begin
          phase_next = SCAN_FIND;
        end
      end
      SCAN_FIND: begin
        if (idx_end) begin
          phase_next = SCAN_IDLE;
        end else if (idx_hit) begin
          phase_next = SCAN_EXTEND;
        end
      end
      SCAN_EXTEND: begin
        if (!extend_ok) begin
          phase_next = SCAN_IDLE;
        end
      end
      default: phase_next = SCAN_IDLE;
    endcase
  end

  // Status outputs
  always_comb begin
    stat.active    = active;
    stat.any_dirty = |dirty;
    stat.scan_done = done_pulse;
    stat.run_found = found;
    stat.run_first = run_first;
    stat.run_count = run_len;
    stat.sync      = ~|dirty;
  end

  // Mask updates and scan stepping; a run's bits drop as they join it unless
  // the sink failed, in which case they stay set
  always_ff @(posedge clk) begin
    if (rst) begin
      dirty      <= '0;
      active     <= 1'b0;
      phase      <= SCAN_IDLE;
      done_pulse <= 1'b0;
      found      <= 1'b0;
    end else begin
      phase      <= phase_next;
      done_pulse <= 1'b0;
      case (cmd.op)
        DM_ACTIVATE: begin
          if (!active) begin
            active <= 1'b1;
            dirty  <= '0;
          end
        end
        DM_MARK: begin
          active <= 1'b1;
          dirty  <= (active ? dirty : '0) | line_mask(cmd.first_line)
                    | line_mask(cmd.last_line);
        end
        DM_SCAN: begin
          idx  <= '0;
          keep <= !cmd.sink_ok;
        end
        default: ;
      endcase
      case (phase)
        SCAN_FIND: begin
          if (idx_end) begin
            done_pulse <= 1'b1;
            found      <= 1'b0;
            run_first  <= '0;
            run_len    <= '0;
          end else begin
            if (idx_hit) begin
              run_first <= idx[LINE_IDX_W-1:0];
              run_len   <= RUN_CNT_W'(1);
              if (!keep) begin
                dirty[idx[LINE_IDX_W-1:0]] <= 1'b0;
              end
            end
            idx <= idx + 1'b1;
          end
        end
        SCAN_EXTEND: begin
          if (extend_ok) begin
            run_len <= run_len + 1'b1;
            idx     <= idx + 1'b1;
            if (!keep) begin
              dirty[idx[LINE_IDX_W-1:0]] <= 1'b0;
            end
          end else begin
            done_pulse <= 1'b1;
            found      <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  a_run_len_bounded: assert property (@(posedge clk) disable iff (rst)
    (done_pulse && found) |-> (run_len != '0 && run_len <= RUN_CNT_W'(MAX_RUN_LINES)))
    else $error("flush run length out of bounds");

  a_mark_activates: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == DM_MARK) |=> (active && dirty != '0))
    else $error("marked write left map inactive or clean");

  a_scan_single_done: assert property (@(posedge clk) disable iff (rst)
    done_pulse |=> !done_pulse)
    else $error("scan completion repeated");

endmodule

### verif/dirty_line_write_back_store_unit_test.sv
`timescale 1ns / 1ps
// Self-checking test of the dirty-line write-back byte store: directed and random commands.
module dirty_line_write_back_store_unit_test;
  import dlwb_pkg::*;

  // Codes the package leaves unnamed
  localparam logic [1:0] KIND_NONE = 2'd3;
  localparam logic [1:0] SIZE_NONE = 2'd3;

  localparam int QUIET_LIMIT  = 20000;
  localparam int DRAIN_CYCLES = 40;
  localparam int REPORT_LIMIT = 10;
  localparam int GAP_CAP      = 20;

  logic      clk   = 1'b0;
  logic      rst   = 1'b1;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  item  = '0;
  logic      done;
  out_item_t result;

  // Mirror of the store contents and its dirty-line map
  logic [7:0]            mirror_bytes [STORE_BYTES];
  logic [LINE_COUNT-1:0] dirty_map;
  logic                  mirror_live;

  out_item_t due_results [$];
  int        idle_pct     = 27;
  int        fault_count  = 0;
  int        quiet_cycles = 0;

  dirty_line_write_back_store_unit dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // First read or changing write after reset starts the store with a clean dirty map
  function automatic void wake_mirror();
    if (!mirror_live) begin
      mirror_live = 1'b1;
      dirty_map   = '0;
    end
  endfunction

  // Apply one command to the mirror and return the result it should produce
  function automatic out_item_t mirror_command(input in_item_t cmd);
    out_item_t             r;
    int                    len;
    int                    base;
    int                    first;
    int                    last;
    int                    n;
    logic                  differs;
    logic [LINE_COUNT-1:0] run;
    r    = '0;
    base = cmd.address;
    if (cmd.kind == KIND_READ || cmd.kind == KIND_WRITE) begin
      case (cmd.access_size)
        SIZE_1:  len = 1;
        SIZE_2:  len = 2;
        SIZE_4:  len = 4;
        default: len = 0;
      endcase
      if (len != 0 && base + len <= STORE_BYTES) begin
        r.in_range = 1'b1;
        if (cmd.kind == KIND_READ) begin
          wake_mirror();
          for (int k = 0; k < len; k++) r.read_value[8*k +: 8] = mirror_bytes[base + k];
        end else begin
          differs = 1'b0;
          for (int k = 0; k < len; k++)
            if (mirror_bytes[base + k] != cmd.write_value[8*k +: 8]) differs = 1'b1;
          if (differs) begin
            wake_mirror();
            for (int k = 0; k < len; k++) mirror_bytes[base + k] = cmd.write_value[8*k +: 8];
            first = base >> LINE_SHIFT;
            last  = (base + len - 1) >> LINE_SHIFT;
            // Mark every touched line, the straddled second one included
            for (int l = first; l <= last; l++)
              if (l < LINE_COUNT) dirty_map[l] = 1'b1;
          end
        end
      end
    end else if (cmd.kind == KIND_FLUSH && mirror_live && dirty_map != '0) begin
      // Find the lowest dirty line, then extend over contiguous dirty lines
      first = 0;
      while (!dirty_map[first]) first++;
      run        = '0;
      run[first] = 1'b1;
      n          = 1;
      while (first + n < LINE_COUNT && n < MAX_RUN_LINES && dirty_map[first + n]) begin
        run[first + n] = 1'b1;
        n++;
      end
      dirty_map &= ~run;
      if (!cmd.sink_ok) dirty_map |= run;
      r.flush_valid      = 1'b1;
      r.flush_first_line = 5'(first);
      r.flush_line_count = 4'(n);
      r.sync_request     = (dirty_map == '0);
    end
    return r;
  endfunction

  function automatic in_item_t make_cmd(input logic [1:0] kind, input logic [15:0] address,
                                        input logic [1:0] size, input logic [31:0] value,
                                        input logic sink_ok);
    in_item_t c;
    c.kind        = kind;
    c.address     = address;
    c.access_size = size;
    c.write_value = value;
    c.sink_ok     = sink_ok;
    return c;
  endfunction

  // Hold the command on the ports until the transfer, then record its result
  task automatic send_command(input in_item_t cmd);
    int gap;
    gap = 0;
    while (gap < GAP_CAP && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item  <= cmd;
    do @(posedge clk); while (busy !== 1'b0);
    due_results.push_back(mirror_command(cmd));
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      fault_count++;
      if (fault_count <= REPORT_LIMIT)
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endtask

  // Compare each result transfer against the oldest outstanding one
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (!rst && done === 1'b1) begin
      if (due_results.size() == 0) begin
        fault_count++;
        if (fault_count <= REPORT_LIMIT)
          $display("%0t: result with none outstanding, got %h", $time, result);
      end else begin
        want = due_results.pop_front();
        check_field("read_value", want.read_value, result.read_value);
        check_field("in_range", want.in_range, result.in_range);
        check_field("flush_valid", want.flush_valid, result.flush_valid);
        check_field("flush_first_line", want.flush_first_line, result.flush_first_line);
        check_field("flush_line_count", want.flush_line_count, result.flush_line_count);
        check_field("sync_request", want.sync_request, result.sync_request);
      end
    end
  end

  // Stop the run when no transfer happens for too long
  always @(posedge clk) begin
    if ((start && busy === 1'b0) || done === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Flush tick before the store is active, and the unused kind
  task automatic test_idle_flush();
    send_command(make_cmd(KIND_FLUSH, 16'h0000, SIZE_1, 32'h0, 1'b1));
    send_command(make_cmd(KIND_NONE, 16'hFFFF, SIZE_NONE, 32'hFFFF_FFFF, 1'b1));
  endtask

  // Sizes, byte order, store end, out-of-range and unused size
  task automatic test_access_edges();
    send_command(make_cmd(KIND_READ, 16'h0000, SIZE_1, 32'h0, 1'b0));
    send_command(make_cmd(KIND_FLUSH, 16'h0000, SIZE_1, 32'h0, 1'b1));
    send_command(make_cmd(KIND_WRITE, 16'h0000, SIZE_4, 32'hFFFF_FFFF, 1'b0));
    send_command(make_cmd(KIND_WRITE, 16'h0000, SIZE_4, 32'hFFFF_FFFF, 1'b0));
    send_command(make_cmd(KIND_READ, 16'h0000, SIZE_4, 32'h0, 1'b0));
    send_command(make_cmd(KIND_WRITE, 16'd126, SIZE_4, 32'h5A3C_A5C3, 1'b0));
    send_command(make_cmd(KIND_READ, 16'd125, SIZE_4, 32'h0, 1'b0));
    send_command(make_cmd(KIND_WRITE, 16'd4095, SIZE_1, 32'h0000_0080, 1'b0));
    send_command(make_cmd(KIND_WRITE, 16'd4094, SIZE_2, 32'h0000_1234, 1'b0));
    send_command(make_cmd(KIND_READ, 16'd4092, SIZE_4, 32'h0, 1'b0));
    send_command(make_cmd(KIND_WRITE, 16'd4093, SIZE_4, 32'hDEAD_BEEF, 1'b0));
    send_command(make_cmd(KIND_READ, 16'd4095, SIZE_2, 32'h0, 1'b0));
    send_command(make_cmd(KIND_READ, 16'hFFFF, SIZE_4, 32'h0, 1'b0));
    send_command(make_cmd(KIND_WRITE, 16'd8, SIZE_NONE, 32'h1357_9BDF, 1'b0));
    send_command(make_cmd(KIND_READ, 16'd8, SIZE_NONE, 32'h0, 1'b0));
  endtask

  // Failed sink, longest run, remainder run and the sync request
  task automatic test_flush_runs();
    send_command(make_cmd(KIND_FLUSH, 16'h0000, SIZE_1, 32'h0, 1'b0));
    send_command(make_cmd(KIND_FLUSH, 16'h0000, SIZE_1, 32'h0, 1'b1));
    for (int k = 2; k <= 10; k += 2)
      send_command(make_cmd(KIND_WRITE, 16'((k << LINE_SHIFT) + 126), SIZE_4,
                            32'hC0DE_0000 | 32'(k), 1'b0));
    repeat (4) send_command(make_cmd(KIND_FLUSH, 16'h0000, SIZE_1, 32'h0, 1'b1));
  endtask

  // Mostly well-formed accesses and flushes, with a share of malformed ones
  function automatic in_item_t pick_command();
    in_item_t c;
    int       roll;
    int       line;
    int       base;
    roll = $urandom_range(99);
    if (roll < 42)      c.kind = KIND_WRITE;
    else if (roll < 75) c.kind = KIND_READ;
    else if (roll < 95) c.kind = KIND_FLUSH;
    else                c.kind = KIND_NONE;
    roll = $urandom_range(99);
    if (roll < 55) begin
      base = $urandom_range(STORE_BYTES - 1);
    end else if (roll < 80) begin
      line = $urandom_range(LINE_COUNT - 1);
      base = ((line + 1) << LINE_SHIFT) - $urandom_range(1, 4);
    end else if (roll < 92) begin
      base = $urandom_range(15);
    end else begin
      base = $urandom_range(16'hFFFF);
    end
    c.address     = 16'(base);
    c.access_size = ($urandom_range(99) < 90) ? 2'($urandom_range(2)) : SIZE_NONE;
    c.write_value = $urandom();
    // Rewrite the stored bytes now and then so the unchanged-write path is taken
    if ($urandom_range(99) < 20)
      for (int k = 0; k < 4; k++)
        if (base + k < STORE_BYTES) c.write_value[8*k +: 8] = mirror_bytes[base + k];
    c.sink_ok = ($urandom_range(99) < 80);
    return c;
  endfunction

  task automatic test_random_traffic(input int count, input int sender_idle);
    idle_pct = sender_idle;
    repeat (count) send_command(pick_command());
  endtask

  initial begin
    for (int a = 0; a < STORE_BYTES; a++) mirror_bytes[a] = 8'h00;
    dirty_map   = '0;
    mirror_live = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_idle_flush();
    test_access_edges();
    test_flush_runs();
    test_random_traffic(250, 27);
    test_random_traffic(250, 51);
    test_random_traffic(250, 0);
    start <= 1'b0;

    // Drain outstanding results, then give the block time to show any stray one
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### dirty_line_write_back_store_unit.f
src/dlwb_pkg.sv
src/dlwb_byte_ram.sv
src/dlwb_dirty_map.sv
src/dirty_line_write_back_store_unit.sv
verif/dirty_line_write_back_store_unit_test.sv
